FILE: sv/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset.
`define PSTG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define PSTG_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/pstg_pkg.sv
// ---------------------------------------------------------------------------
// pstg_pkg
// Shared widths, register indexes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package pstg_pkg;

   localparam int COEF_W = 31;
   localparam int DEG_W  = 5;
   localparam int CNT_W  = 7;
   localparam int CSR_W  = 2;
   localparam int PROD_W = 2 * COEF_W;

   localparam int DEF_MAX_DEGREE = 16;
   localparam int DEF_MAX_TRACES = 64;

   localparam logic [CSR_W-1:0] CSR_MODULUS     = 2'd0;
   localparam logic [CSR_W-1:0] CSR_DEGREE      = 2'd1;
   localparam logic [CSR_W-1:0] CSR_TRACE_COUNT = 2'd2;

   localparam logic [COEF_W-1:0] MOD_FLOOR = 31'd2;

   typedef struct packed {
      logic red_start;
      logic red_sel_coef;
      logic sym_we;
      logic sym_neg;
      logic mul_en;
      logic mul_tail;
      logic acc_clr;
      logic acc_add;
      logic acc_sub;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic red_done;
   } dp_sts_type;

endpackage

FILE: sv/pstg_ram.sv
// ---------------------------------------------------------------------------
// pstg_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pstg_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/pstg_modred.sv
// ---------------------------------------------------------------------------
// pstg_modred
// Bit-serial remainder unit: reduces a full-width product by the modulus,
// one dividend bit per cycle.
// ---------------------------------------------------------------------------
module pstg_modred (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pstg_pkg::PROD_W-1:0]   dividend,
   input  logic [pstg_pkg::COEF_W-1:0]   md,
   output logic                          done,
   output logic [pstg_pkg::COEF_W-1:0]   rem
);

   localparam int PW = pstg_pkg::PROD_W;
   localparam int CW = pstg_pkg::COEF_W;
   localparam int NW = $clog2(PW);
   localparam logic [NW-1:0] LAST = NW'(PW - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] sh_ff, sh_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, sh_ff[PW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, md}) begin
            trial = trial - {1'b0, md};
         end
         rem_in = trial[CW-1:0];
         sh_in  = {sh_ff[PW-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

FILE: sv/pstg_dp.sv
// ---------------------------------------------------------------------------
// pstg_dp
// Datapath: coefficient and trace stores, multiplier, remainder unit and
// modular accumulator.
// ---------------------------------------------------------------------------
module pstg_dp #(
   parameter int MAX_DEGREE = pstg_pkg::DEF_MAX_DEGREE,
   parameter int MAX_TRACES = pstg_pkg::DEF_MAX_TRACES,
   localparam int W   = $clog2(((MAX_DEGREE > MAX_TRACES) ? MAX_DEGREE : MAX_TRACES) + 1),
   localparam int SAW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1,
   localparam int TAW = (MAX_TRACES > 1) ? $clog2(MAX_TRACES) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pstg_pkg::dp_cmd_type        cmd,
   output pstg_pkg::dp_sts_type        sts,
   input  logic [pstg_pkg::COEF_W-1:0] md,
   input  logic [pstg_pkg::COEF_W-1:0] req_coefficient,
   input  logic [SAW-1:0]              sym_waddr,
   input  logic [SAW-1:0]              sym_raddr,
   input  logic [TAW-1:0]              trace_waddr,
   input  logic [TAW-1:0]              trace_raddr,
   input  logic [W-1:0]                tail_k,
   output logic [pstg_pkg::COEF_W-1:0] rsp_trace_value
);

   localparam int CW = pstg_pkg::COEF_W;
   localparam int PW = pstg_pkg::PROD_W;

   logic [CW-1:0] sym_rdata, trace_rdata, sym_wdata, rem;
   logic [PW-1:0] prod_ff, prod_in, dividend;
   logic [CW-1:0] acc_ff, acc_in, value_ff;
   logic [CW-1:0] mul_a;
   logic [CW:0]   sum, diff;
   logic          red_done;

   pstg_ram #(.WIDTH(CW), .DEPTH(MAX_DEGREE)) u_sym (
      .clock (clock),
      .we    (cmd.sym_we),
      .waddr (sym_waddr),
      .wdata (sym_wdata),
      .raddr (sym_raddr),
      .rdata (sym_rdata)
   );

   pstg_ram #(.WIDTH(CW), .DEPTH(MAX_TRACES)) u_trace (
      .clock (clock),
      .we    (cmd.out_load),
      .waddr (trace_waddr),
      .wdata (acc_ff),
      .raddr (trace_raddr),
      .rdata (trace_rdata)
   );

   assign dividend = cmd.red_sel_coef ? PW'(req_coefficient) : prod_ff;

   pstg_modred u_red (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.red_start),
      .dividend (dividend),
      .md       (md),
      .done     (red_done),
      .rem      (rem)
   );

   assign sts.red_done = red_done;

   // negate on odd positions: A_j = (-1)^j * c
   assign sym_wdata = (cmd.sym_neg && rem != '0) ? md - rem : rem;

   assign mul_a   = cmd.mul_tail ? CW'(tail_k) : trace_rdata;
   assign prod_in = PW'(mul_a) * PW'(sym_rdata);

   assign sum  = {1'b0, acc_ff} + {1'b0, rem};
   assign diff = {1'b0, acc_ff} + {1'b0, md} - {1'b0, rem};

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         acc_in = (sum >= {1'b0, md}) ? CW'(sum - {1'b0, md}) : sum[CW-1:0];
      end else if (cmd.acc_sub) begin
         acc_in = (acc_ff >= rem) ? acc_ff - rem : diff[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.out_load) begin
         value_ff <= acc_ff;
      end
      acc_ff <= acc_in;
   end

   assign rsp_trace_value = value_ff;

endmodule

FILE: sv/pstg_ctrl.sv
// ---------------------------------------------------------------------------
// pstg_ctrl
// Controller: load counter, trace and term counters, sequencing of the
// datapath and the result word register.
// ---------------------------------------------------------------------------
module pstg_ctrl #(
   parameter int MAX_DEGREE = pstg_pkg::DEF_MAX_DEGREE,
   parameter int MAX_TRACES = pstg_pkg::DEF_MAX_TRACES,
   localparam int W   = $clog2(((MAX_DEGREE > MAX_TRACES) ? MAX_DEGREE : MAX_TRACES) + 1),
   localparam int SAW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1,
   localparam int TAW = (MAX_TRACES > 1) ? $clog2(MAX_TRACES) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [pstg_pkg::CNT_W-1:0] rsp_trace_index,
   output logic                       rsp_last_trace,
   input  logic [pstg_pkg::DEG_W-1:0] degree,
   input  logic [pstg_pkg::CNT_W-1:0] trace_count,
   output pstg_pkg::dp_cmd_type       cmd,
   input  pstg_pkg::dp_sts_type       sts,
   output logic [SAW-1:0]             sym_waddr,
   output logic [SAW-1:0]             sym_raddr,
   output logic [TAW-1:0]             trace_waddr,
   output logic [TAW-1:0]             trace_raddr,
   output logic [W-1:0]               tail_k
);

   localparam int CNW = pstg_pkg::CNT_W;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_CRED  = 10'b00_0000_0010,
      ST_TINIT = 10'b00_0000_0100,
      ST_CHK   = 10'b00_0000_1000,
      ST_RD    = 10'b00_0001_0000,
      ST_MUL   = 10'b00_0010_0000,
      ST_RED   = 10'b00_0100_0000,
      ST_RWAIT = 10'b00_1000_0000,
      ST_ACC   = 10'b01_0000_0000,
      ST_EMIT  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [W-1:0]   load_ff, load_in;
   logic [W-1:0]   k_ff, k_in;
   logic [W-1:0]   j_ff, j_in;
   logic           tail_ff, tail_in;
   logic           rvalid_ff, rvalid_in;
   logic [CNW-1:0] idx_ff, idx_in;
   logic           last_ff, last_in;

   logic [7:0]   d8, n8, m8, nn8;
   logic [W-1:0] m, n, lim, j1, sym_ra, tr_ra, tr_wa;

   // saturate degree and count into their legal ranges
   always_comb begin
      d8  = 8'(degree);
      n8  = 8'(trace_count);
      m8  = (d8 == 8'd0) ? 8'd1 : ((d8 > 8'(MAX_DEGREE)) ? 8'(MAX_DEGREE) : d8);
      nn8 = (n8 == 8'd0) ? 8'd1 : ((n8 > 8'(MAX_TRACES)) ? 8'(MAX_TRACES) : n8);
   end

   assign m   = W'(m8);
   assign n   = W'(nn8);
   assign lim = (k_ff <= m) ? k_ff - 1'b1 : m;
   assign j1  = load_ff + 1'b1;

   assign sym_ra      = tail_ff ? k_ff - 1'b1 : j_ff - 1'b1;
   assign tr_ra       = k_ff - j_ff - 1'b1;
   assign tr_wa       = k_ff - 1'b1;
   assign sym_raddr   = sym_ra[SAW-1:0];
   assign sym_waddr   = load_ff[SAW-1:0];
   assign trace_raddr = tr_ra[TAW-1:0];
   assign trace_waddr = tr_wa[TAW-1:0];
   assign tail_k      = k_ff;

   always_comb begin
      state_in  = state_ff;
      load_in   = load_ff;
      k_in      = k_ff;
      j_in      = j_ff;
      tail_in   = tail_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      rvalid_in = rvalid_ff && rsp_stall;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.red_start    = 1'b1;
               cmd.red_sel_coef = 1'b1;
               state_in         = ST_CRED;
            end
         end
         ST_CRED: begin
            if (sts.red_done) begin
               cmd.sym_we  = 1'b1;
               cmd.sym_neg = j1[0];
               if (j1 < m) begin
                  load_in  = j1;
                  state_in = ST_IDLE;
               end else begin
                  load_in  = '0;
                  k_in     = W'(1);
                  state_in = ST_TINIT;
               end
            end
         end
         ST_TINIT: begin
            cmd.acc_clr = 1'b1;
            j_in        = W'(1);
            tail_in     = 1'b0;
            state_in    = ST_CHK;
         end
         ST_CHK: begin
            priority if (j_ff <= lim) begin
               state_in = ST_RD;
            end else if (k_ff <= m) begin
               tail_in  = 1'b1;
               state_in = ST_RD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_RD: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_tail = tail_ff;
            state_in     = ST_RED;
         end
         ST_RED: begin
            cmd.red_start = 1'b1;
            state_in      = ST_RWAIT;
         end
         ST_RWAIT: begin
            if (sts.red_done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.acc_add = tail_ff ? k_ff[0] : j_ff[0];
            cmd.acc_sub = !cmd.acc_add;
            if (tail_ff) begin
               state_in = ST_EMIT;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_CHK;
            end
         end
         ST_EMIT: begin
            // advance only when the output word register is free
            if (!rvalid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rvalid_in    = 1'b1;
               idx_in       = CNW'(k_ff);
               last_in      = (k_ff == n);
               if (k_ff == n) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_TINIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         load_ff   <= '0;
         k_ff      <= '0;
         j_ff      <= '0;
         tail_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         load_ff   <= load_in;
         k_ff      <= k_in;
         j_ff      <= j_in;
         tail_ff   <= tail_in;
         rvalid_ff <= rvalid_in;
      end
      idx_ff  <= idx_in;
      last_ff <= last_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rvalid_ff;
   assign rsp_trace_index = idx_ff;
   assign rsp_last_trace  = last_ff;

endmodule

FILE: sv/power_sum_trace_generator_top.sv
// ---------------------------------------------------------------------------
// power_sum_trace_generator_top
// Power-sum traces of a monic polynomial modulo a configured modulus.
// ---------------------------------------------------------------------------
// Usage:
//   csr_*  : write modulus (0), degree (1), trace_count (2) while idle.
//   req_*  : one coefficient word per item, highest power first; degree
//            words load one polynomial.
//   rsp_*  : after the last coefficient, trace_count words T1..TN follow,
//            rsp_last_trace marking TN.
// Sequence: each coefficient word is accepted, reduced by the modulus in
//   62 serial bit steps, and stored. Each trace term is a check, read,
//   multiply, reduction start, 62 bit steps, done and accumulate; trace k
//   has min(k-1, m) terms plus one more when k <= m, plus clear and emit,
//   and one more check when k > m.
// Reset clears the controller and sets modulus 2, degree 1, trace count 1.
// A stalled result word holds in the output register; the next trace waits
// until that register is free. The input is ready only between items.
// ---------------------------------------------------------------------------
module power_sum_trace_generator_top #(
   parameter int MAX_DEGREE = pstg_pkg::DEF_MAX_DEGREE,
   parameter int MAX_TRACES = pstg_pkg::DEF_MAX_TRACES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [pstg_pkg::COEF_W-1:0] req_coefficient,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pstg_pkg::CNT_W-1:0]  rsp_trace_index,
   output logic [pstg_pkg::COEF_W-1:0] rsp_trace_value,
   output logic                        rsp_last_trace,
   input  logic                        csr_write_enable,
   input  logic [pstg_pkg::CSR_W-1:0]  csr_index,
   input  logic [pstg_pkg::COEF_W-1:0] csr_write_data
);

   localparam int W   = $clog2(((MAX_DEGREE > MAX_TRACES) ? MAX_DEGREE : MAX_TRACES) + 1);
   localparam int SAW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int TAW = (MAX_TRACES > 1) ? $clog2(MAX_TRACES) : 1;

   logic [pstg_pkg::COEF_W-1:0] modulus_ff;
   logic [pstg_pkg::DEG_W-1:0]  degree_ff;
   logic [pstg_pkg::CNT_W-1:0]  trace_count_ff;
   logic [pstg_pkg::COEF_W-1:0] md;

   pstg_pkg::dp_cmd_type cmd;
   pstg_pkg::dp_sts_type sts;
   logic [SAW-1:0] sym_waddr, sym_raddr;
   logic [TAW-1:0] trace_waddr, trace_raddr;
   logic [W-1:0]   tail_k;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff     <= pstg_pkg::MOD_FLOOR;
         degree_ff      <= pstg_pkg::DEG_W'(1);
         trace_count_ff <= pstg_pkg::CNT_W'(1);
      end else if (csr_write_enable) begin
         if (csr_index == pstg_pkg::CSR_MODULUS) begin
            modulus_ff <= csr_write_data;
         end
         if (csr_index == pstg_pkg::CSR_DEGREE) begin
            degree_ff <= csr_write_data[pstg_pkg::DEG_W-1:0];
         end
         if (csr_index == pstg_pkg::CSR_TRACE_COUNT) begin
            trace_count_ff <= csr_write_data[pstg_pkg::CNT_W-1:0];
         end
      end
   end

   assign md = (modulus_ff < pstg_pkg::MOD_FLOOR) ? pstg_pkg::MOD_FLOOR : modulus_ff;

   pstg_ctrl #(.MAX_DEGREE(MAX_DEGREE), .MAX_TRACES(MAX_TRACES)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_trace_index (rsp_trace_index),
      .rsp_last_trace  (rsp_last_trace),
      .degree          (degree_ff),
      .trace_count     (trace_count_ff),
      .cmd             (cmd),
      .sts             (sts),
      .sym_waddr       (sym_waddr),
      .sym_raddr       (sym_raddr),
      .trace_waddr     (trace_waddr),
      .trace_raddr     (trace_raddr),
      .tail_k          (tail_k)
   );

   pstg_dp #(.MAX_DEGREE(MAX_DEGREE), .MAX_TRACES(MAX_TRACES)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .md              (md),
      .req_coefficient (req_coefficient),
      .sym_waddr       (sym_waddr),
      .sym_raddr       (sym_raddr),
      .trace_waddr     (trace_waddr),
      .trace_raddr     (trace_raddr),
      .tail_k          (tail_k),
      .rsp_trace_value (rsp_trace_value)
   );

endmodule

FILE: sv/pstg_checker.sv
// ---------------------------------------------------------------------------
// pstg_checker
// Port-level checks on the trace generator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pstg_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [pstg_pkg::CNT_W-1:0]  rsp_trace_index,
   input logic [pstg_pkg::COEF_W-1:0] rsp_trace_value,
   input logic                        rsp_last_trace
);

   `PSTG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_trace_value) && $stable(rsp_trace_index) && $stable(rsp_last_trace), "stalled result word changed")
   `PSTG_ASSERT_NR(a_reset_quiet, clock, reset |=> !rsp_valid && !req_stall, "not idle after reset")
   `PSTG_ASSERT(a_index_nonzero, clock, reset, rsp_valid |-> rsp_trace_index != '0, "trace index zero")
   `PSTG_ASSERT(a_busy_after_accept, clock, reset, req_valid && !req_stall |=> req_stall, "input ready right after accept")

endmodule

bind power_sum_trace_generator_top pstg_checker u_pstg_checker (.*);
